// ===== sv/mse_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mse_pkg
// Shared constants, controller states and the command and status records
// that join the merge sort controller and datapath.
// ----------------------------------------------------------------------------
package mse_pkg;

  localparam int unsigned MaxKeys = 64;
  localparam int unsigned KeyW    = 32;
  localparam int unsigned AddrW   = $clog2(MaxKeys);
  localparam int unsigned CntW    = AddrW + 1;
  localparam int unsigned PaddrW  = 3;
  localparam int unsigned PdataW  = 32;

  localparam logic RegDescending = 1'b0;

  typedef enum logic [2:0] {
    S_LOAD,
    S_PASS,
    S_RUN,
    S_MERGE,
    S_EMIT_RD,
    S_EMIT_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic sort_init;
    logic pass_init;
    logic run_init;
    logic merge_step;
    logic run_next;
    logic pass_next;
    logic emit_init;
    logic emit_next;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic width_ge_n;
    logic run_end;
    logic pass_end;
    logic emit_last;
  } sts_t;

endpackage
`default_nettype wire

// ===== sv/mse_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mse_ctrl
// Sequencer for loading, the bottom-up merge passes and emission.
// ----------------------------------------------------------------------------
module mse_ctrl
  import mse_pkg::*;
(
  input  wire  logic clk_i,
  input  wire  logic rst_ni,
  input  wire  logic in_valid_i,
  input  wire  logic in_last_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  wire  logic out_ready_i,
  input  wire  sts_t sts_i,
  output cmd_t       cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_LOAD: begin
        if (in_valid_i && in_last_i) begin
          state_d = S_PASS;
        end
      end
      S_PASS: begin
        state_d = sts_i.width_ge_n ? S_EMIT_RD : S_RUN;
      end
      S_RUN: begin
        state_d = S_MERGE;
      end
      S_MERGE: begin
        if (sts_i.run_end) begin
          state_d = sts_i.pass_end ? S_PASS : S_RUN;
        end
      end
      S_EMIT_RD: begin
        state_d = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        if (out_ready_i) begin
          state_d = sts_i.emit_last ? S_LOAD : S_EMIT_RD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_LOAD: begin
        in_ready_o     = 1'b1;
        cmd_o.load     = in_valid_i;
        cmd_o.sort_init = in_valid_i && in_last_i;
      end
      S_PASS: begin
        cmd_o.emit_init = sts_i.width_ge_n;
        cmd_o.pass_init = !sts_i.width_ge_n;
      end
      S_RUN: begin
        cmd_o.run_init = 1'b1;
      end
      S_MERGE: begin
        cmd_o.merge_step = 1'b1;
        cmd_o.run_next   = sts_i.run_end;
        cmd_o.pass_next  = sts_i.run_end && sts_i.pass_end;
      end
      S_EMIT_RD: begin
      end
      S_EMIT_OUT: begin
        out_valid_o     = 1'b1;
        cmd_o.emit_next = out_ready_i && !sts_i.emit_last;
        cmd_o.finish    = out_ready_i && sts_i.emit_last;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/mse_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mse_dpath
// Ping-pong key stores, run pointers and the merge compare.
// ----------------------------------------------------------------------------
module mse_dpath
  import mse_pkg::*;
(
  input  wire  logic            clk_i,
  input  wire  logic            rst_ni,
  input  wire  cmd_t            cmd_i,
  input  wire  logic [KeyW-1:0] key_i,
  input  wire  logic            descending_i,
  output sts_t                  sts_o,
  output logic [KeyW-1:0]       key_o,
  output logic                  final_o,
  output logic                  overflowed_o
);

  logic [KeyW-1:0] mem_a [MaxKeys];
  logic [KeyW-1:0] mem_b [MaxKeys];

  logic [CntW-1:0] fill_q, fill_d;
  logic            ovf_q, ovf_d;
  logic            desc_q, desc_d;
  logic            src_b_q, src_b_d;
  logic            emit_q, emit_d;
  logic [CntW-1:0] width_q, width_d;
  logic [CntW-1:0] lo_q, lo_d;
  logic [CntW-1:0] i_q, i_d;
  logic [CntW-1:0] j_q, j_d;
  logic [CntW-1:0] k_q, k_d;
  logic [CntW-1:0] e_q, e_d;

  logic [CntW:0]   mid_sum, hi_sum;
  logic [CntW-1:0] mid, hi;
  logic [CntW-1:0] k_dec;
  logic [AddrW-1:0] ra, rb;
  logic [KeyW-1:0] rd_aa_q, rd_ab_q, rd_ba_q, rd_bb_q;
  logic [KeyW-1:0] head_a, head_b, wdata;
  logic            take_a, goes_after;

  assign mid_sum = {1'b0, lo_q} + {1'b0, width_q};
  assign hi_sum  = {1'b0, lo_q} + {width_q, 1'b0};
  assign mid     = (mid_sum > {1'b0, fill_q}) ? fill_q : mid_sum[CntW-1:0];
  assign hi      = (hi_sum > {1'b0, fill_q}) ? fill_q : hi_sum[CntW-1:0];
  assign k_dec   = k_q - CntW'(1);

  assign head_a = src_b_q ? rd_ba_q : rd_aa_q;
  assign head_b = src_b_q ? rd_bb_q : rd_ab_q;

  assign goes_after = desc_q ? (head_a < head_b) : (head_a > head_b);
  assign take_a     = (i_q != lo_q) && ((j_q == mid) || goes_after);
  assign wdata      = take_a ? head_a : head_b;

  always_comb begin
    fill_d  = fill_q;
    ovf_d   = ovf_q;
    desc_d  = desc_q;
    src_b_d = src_b_q;
    emit_d  = emit_q;
    width_d = width_q;
    lo_d    = lo_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    e_d     = e_q;
    if (cmd_i.load) begin
      if (fill_q < CntW'(MaxKeys)) begin
        fill_d = fill_q + CntW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
    if (cmd_i.sort_init) begin
      desc_d  = descending_i;
      src_b_d = 1'b0;
      width_d = CntW'(1);
    end
    if (cmd_i.pass_init) begin
      lo_d = '0;
    end
    if (cmd_i.run_init) begin
      i_d = mid;
      j_d = hi;
      k_d = hi;
    end
    if (cmd_i.merge_step) begin
      k_d = k_dec;
      if (take_a) begin
        i_d = i_q - CntW'(1);
      end else begin
        j_d = j_q - CntW'(1);
      end
    end
    if (cmd_i.run_next) begin
      lo_d = hi_sum[CntW-1:0];
    end
    if (cmd_i.pass_next) begin
      width_d = {width_q[CntW-2:0], 1'b0};
      src_b_d = !src_b_q;
    end
    if (cmd_i.emit_init) begin
      emit_d = 1'b1;
      e_d    = '0;
    end
    if (cmd_i.emit_next) begin
      e_d = e_q + CntW'(1);
    end
    if (cmd_i.finish) begin
      emit_d = 1'b0;
      fill_d = '0;
      ovf_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      ovf_q   <= 1'b0;
      desc_q  <= 1'b0;
      src_b_q <= 1'b0;
      emit_q  <= 1'b0;
    end else begin
      fill_q  <= fill_d;
      ovf_q   <= ovf_d;
      desc_q  <= desc_d;
      src_b_q <= src_b_d;
      emit_q  <= emit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    width_q <= width_d;
    lo_q    <= lo_d;
    i_q     <= i_d;
    j_q     <= j_d;
    k_q     <= k_d;
    e_q     <= e_d;
  end

  // During the merge passes, reads are addressed by the next pointer values so
  // that the registered data always holds the current head of each run.
  always_comb begin
    ra = emit_q ? e_q[AddrW-1:0] : AddrW'(i_d - CntW'(1));
    rb = AddrW'(j_d - CntW'(1));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (fill_q < CntW'(MaxKeys))) begin
      mem_a[fill_q[AddrW-1:0]] <= key_i;
    end else if (cmd_i.merge_step && src_b_q) begin
      mem_a[k_dec[AddrW-1:0]] <= wdata;
    end
    rd_aa_q <= mem_a[ra];
    rd_ab_q <= mem_a[rb];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.merge_step && !src_b_q) begin
      mem_b[k_dec[AddrW-1:0]] <= wdata;
    end
    rd_ba_q <= mem_b[ra];
    rd_bb_q <= mem_b[rb];
  end

  assign sts_o.width_ge_n = (width_q >= fill_q);
  assign sts_o.run_end    = (k_q == lo_q + CntW'(1));
  assign sts_o.pass_end   = (hi_sum >= {1'b0, fill_q});
  assign sts_o.emit_last  = (e_q + CntW'(1) == fill_q);

  assign key_o        = head_a;
  assign final_o      = sts_o.emit_last;
  assign overflowed_o = ovf_q;

endmodule
`default_nettype wire

// ===== sv/merge_sort_engine.sv =====
`default_nettype none
// Operation: a set of n keys loads at one word per cycle while the engine is
// loading; then ceil(log2(n)) merge passes run, with a setup step per pass
// and per run pair, and each word is emitted through a read state and
// an output state, set by the registered store read. No key is accepted
// until the last sorted word of the set has gone. Reset (asynchronous, active
// low) empties the set, clears the overflow flag and selects ascending order.
// ----------------------------------------------------------------------------
// merge_sort_engine
// Bottom-up merge sort of up to 64 unsigned keys with stream ports and an
// APB register for the sort order.
// ----------------------------------------------------------------------------
module merge_sort_engine
  import mse_pkg::*;
(
  input  wire  logic              clk_i,
  input  wire  logic              rst_ni,
  input  wire  logic              s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  wire  logic [KeyW-1:0]   s_axis_tdata_i,   // key
  input  wire  logic              s_axis_tlast_i,
  output logic                    m_axis_tvalid_o,
  input  wire  logic              m_axis_tready_i,
  output logic [KeyW-1:0]         m_axis_tdata_o,   // sorted_key
  output logic                    m_axis_tlast_o,
  output logic                    m_axis_tuser_o,   // overflowed
  input  wire  logic              psel_i,
  input  wire  logic              penable_i,
  input  wire  logic              pwrite_i,
  input  wire  logic [PaddrW-1:0] paddr_i,
  input  wire  logic [PdataW-1:0] pwdata_i,
  output logic [PdataW-1:0]       prdata_o,
  output logic                    pready_o
);

  logic descending_q, descending_d;
  logic reg_hit;
  cmd_t cmd;
  sts_t sts;

  assign pready_o = 1'b1;
  assign reg_hit  = (paddr_i[PaddrW-1:2] == RegDescending);

  always_comb begin
    descending_d = descending_q;
    if (psel_i && penable_i && pwrite_i && pready_o && reg_hit) begin
      descending_d = pwdata_i[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      descending_q <= 1'b0;
    end else begin
      descending_q <= descending_d;
    end
  end

  assign prdata_o = reg_hit ? {{(PdataW-1){1'b0}}, descending_q} : '0;

  mse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_last_i   (s_axis_tlast_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mse_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .key_i        (s_axis_tdata_i),
    .descending_i (descending_q),
    .sts_o        (sts),
    .key_o        (m_axis_tdata_o),
    .final_o      (m_axis_tlast_o),
    .overflowed_o (m_axis_tuser_o)
  );

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for merge_sort_engine. Sets of keys are streamed
// into the block and every sorted word that comes out is checked against a
// local model of the sort. The order register is written over APB between
// phases, and both stream sides idle at random in all but the last phase.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mse_pkg::*;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SettleCycles = 32;
  localparam int unsigned PhaseItems   = 130;

  localparam logic [PaddrW-1:0] OrderAddr  = PaddrW'(4 * RegDescending);
  localparam logic [PaddrW-1:0] UnusedAddr = PaddrW'(4);

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic            last;
  } key_word_t;

  typedef struct packed {
    logic [KeyW-1:0] sorted_key;
    logic            final_res;
    logic            overflowed;
  } sort_word_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_valid = 1'b0;
  logic [KeyW-1:0]   s_data = '0;
  logic              s_last = 1'b0;
  logic              m_ready = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [PaddrW-1:0] paddr = '0;
  logic [PdataW-1:0] pwdata = '0;

  wire               s_axis_tready_o;
  wire               m_axis_tvalid_o;
  wire  [KeyW-1:0]   m_axis_tdata_o;
  wire               m_axis_tlast_o;
  wire               m_axis_tuser_o;
  wire  [PdataW-1:0] prdata_o;
  wire               pready_o;

  key_word_t   key_queue [$];
  sort_word_t  sorted_queue [$];

  logic [KeyW-1:0] held_keys [MaxKeys];
  logic [CntW-1:0] held_count = '0;
  logic            held_ovf = 1'b0;
  logic            desc_q = 1'b0;

  int unsigned send_idle_pct = 6;
  int unsigned recv_idle_pct = 59;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned words_in = 0;
  int unsigned words_out = 0;
  int unsigned sets_sorted = 0;
  int unsigned sets_ovf = 0;

  merge_sort_engine DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),    // key
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),   // sorted_key
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o),   // overflowed
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_o        (prdata_o),
    .pready_o        (pready_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic goes_later(input logic [KeyW-1:0] a, input logic [KeyW-1:0] b);
    return desc_q ? (a < b) : (a > b);
  endfunction

  function automatic void take_key(input logic [KeyW-1:0] key, input logic last);
    logic [KeyW-1:0] ordered [MaxKeys];
    logic [KeyW-1:0] v;
    int j;
    words_in++;
    if (held_count < MaxKeys) begin
      held_keys[held_count[AddrW-1:0]] = key;
      held_count++;
    end else begin
      held_ovf = 1'b1;
    end
    if (last) begin
      ordered = held_keys;
      for (int i = 1; i < held_count; i++) begin
        v = ordered[i];
        j = i;
        while (j > 0 && goes_later(ordered[j-1], v)) begin
          ordered[j] = ordered[j-1];
          j--;
        end
        ordered[j] = v;
      end
      for (int k = 0; k < held_count; k++) begin
        sorted_queue.push_back('{sorted_key: ordered[k],
                                 final_res:  (k + 1 == held_count),
                                 overflowed: held_ovf});
      end
      sets_sorted++;
      if (held_ovf) sets_ovf++;
      held_count = '0;
      held_ovf   = 1'b0;
    end
  endfunction

  function automatic logic [KeyW-1:0] pick_key();
    case ($urandom_range(3))
      0: return KeyW'($urandom_range(7));
      1: return $urandom_range(1) ? '1 : '0;
      default: return KeyW'($urandom());
    endcase
  endfunction

  task automatic queue_set(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      key_queue.push_back('{key: pick_key(), last: (i + 1 == n)});
    end
  endtask

  task automatic queue_phase();
    int unsigned total;
    int unsigned n;
    int unsigned r;
    n = $urandom_range(65, 70);
    queue_set(n);
    total = n;
    while (total < PhaseItems) begin
      r = $urandom_range(19);
      if (r == 0) n = MaxKeys;
      else if (r == 1) n = $urandom_range(65, 72);
      else n = $urandom_range(1, 12);
      queue_set(n);
      total += n;
    end
  endtask

  task automatic apb_write(input logic [PaddrW-1:0] addr, input logic [PdataW-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready_o);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == OrderAddr) desc_q = data[0];
  endtask

  task automatic apb_check_order();
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= OrderAddr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready_o);
    if (prdata_o !== PdataW'(desc_q)) begin
      $display("%0t: order register read expected %0h actual %0h",
               $time, PdataW'(desc_q), prdata_o);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_idle();
    while (key_queue.size() != 0 || s_valid || sorted_queue.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : drive_proc
    logic busy;
    key_word_t nxt;
    if (rst_ni) begin
      busy = s_valid;
      if (s_valid && s_axis_tready_o) begin
        take_key(s_data, s_last);
        busy = 1'b0;
      end
      if (!busy) begin
        if (key_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = key_queue.pop_front();
          s_valid <= 1'b1;
          s_data  <= nxt.key;
          s_last  <= nxt.last;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : check_proc
    sort_word_t want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_ready) begin
        words_out++;
        if (sorted_queue.size() == 0) begin
          $display("%0t: unexpected word expected none actual key %0h last %0b ovf %0b",
                   $time, m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o);
          errors++;
        end else begin
          want = sorted_queue.pop_front();
          if (m_axis_tdata_o !== want.sorted_key) begin
            $display("%0t: sorted_key expected %0h actual %0h",
                     $time, want.sorted_key, m_axis_tdata_o);
            errors++;
          end
          if (m_axis_tlast_o !== want.final_res) begin
            $display("%0t: final_res expected %0b actual %0b",
                     $time, want.final_res, m_axis_tlast_o);
            errors++;
          end
          if (m_axis_tuser_o !== want.overflowed) begin
            $display("%0t: overflowed expected %0b actual %0b",
                     $time, want.overflowed, m_axis_tuser_o);
            errors++;
          end
        end
      end
      m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    key_queue.push_back('{key: 32'h0000_0000, last: 1'b1});
    key_queue.push_back('{key: 32'hFFFF_FFFF, last: 1'b1});
    key_queue.push_back('{key: 32'hFFFF_FFFF, last: 1'b0});
    key_queue.push_back('{key: 32'h0000_0000, last: 1'b0});
    key_queue.push_back('{key: 32'h0000_0001, last: 1'b0});
    key_queue.push_back('{key: 32'h0000_0000, last: 1'b0});
    key_queue.push_back('{key: 32'h7FFF_FFFF, last: 1'b0});
    key_queue.push_back('{key: 32'h8000_0000, last: 1'b1});
    key_queue.push_back('{key: 32'h0000_0005, last: 1'b0});
    key_queue.push_back('{key: 32'h0000_0005, last: 1'b0});
    key_queue.push_back('{key: 32'h0000_0003, last: 1'b0});
    key_queue.push_back('{key: 32'h0000_0005, last: 1'b1});
    key_queue.push_back('{key: 32'h0000_0002, last: 1'b0});
    key_queue.push_back('{key: 32'h0000_0001, last: 1'b1});
    wait_idle();
    apb_check_order();

    apb_write(OrderAddr, PdataW'(1));
    apb_check_order();
    @(negedge clk_i);
    queue_phase();
    wait_idle();

    apb_write(OrderAddr, PdataW'(0));
    apb_check_order();
    @(negedge clk_i);
    send_idle_pct = 59;
    recv_idle_pct = 6;
    queue_phase();
    wait_idle();

    apb_write(OrderAddr, PdataW'(1));
    apb_write(UnusedAddr, PdataW'(0));
    apb_check_order();
    @(negedge clk_i);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_phase();
    wait_idle();

    if (sorted_queue.size() != 0) begin
      $display("%0t: %0d sorted words never arrived", $time, sorted_queue.size());
      errors++;
    end
    $display("Sorted %0d sets in both orders, %0d of them past capacity.",
             sets_sorted, sets_ovf);
    $display("Sent %0d key words and checked %0d sorted words.", words_in, words_out);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/mse_pkg.sv
sv/mse_ctrl.sv
sv/mse_dpath.sv
sv/merge_sort_engine.sv
verif/tb.sv
